@@ sv/pqhd_pkg.sv @@
// pqhd_pkg: shared types, mode codes and constellation point tables for the
// hard-decision demapper. No dependencies; used by pqhd_point_gen and psk_qam_hard_demapper.
`timescale 1ns / 1ps
`default_nettype none

package pqhd_pkg;

  typedef logic [2:0] mode_t;

  localparam mode_t MODE_BPSK     = 3'd0;
  localparam mode_t MODE_QPSK     = 3'd1;
  localparam mode_t MODE_8PSK     = 3'd2;
  localparam mode_t MODE_16QAM    = 3'd3;
  localparam mode_t MODE_32QAM    = 3'd4;
  localparam mode_t MODE_64QAM    = 3'd5;
  localparam mode_t MODE_256QAM   = 3'd6;
  localparam mode_t MODE_RESERVED = 3'd7;

  typedef logic [1:0] cfg_index_t;

  localparam cfg_index_t CFG_MODULATION_MODE     = 2'd0;
  localparam cfg_index_t CFG_DIFFERENTIAL_ENABLE = 2'd1;

  // unit amplitudes with 24 fraction bits
  localparam int UNIT_FRAC = 24;

  typedef logic [24:0] unit_t;

  localparam unit_t UNIT_ONE  = 25'd16777216;
  localparam unit_t UNIT_R2   = 25'd11863283;
  localparam unit_t UNIT_R10  = 25'd5305422;
  localparam unit_t UNIT_R20  = 25'd3751500;
  localparam unit_t UNIT_R42  = 25'd2588781;
  localparam unit_t UNIT_R170 = 25'd1286754;

  typedef struct packed {
    logic signed [4:0] level_i;
    logic signed [4:0] level_q;
    unit_t             unit;
  } point_level_t;

  // mode seven decodes as 256-qam
  function automatic mode_t effective_mode(mode_t mode);
    return (mode == MODE_RESERVED) ? MODE_256QAM : mode;
  endfunction

  function automatic logic [3:0] mode_bits(mode_t mode);
    logic [3:0] bits;
    case (mode)
      MODE_BPSK:  bits = 4'd1;
      MODE_QPSK:  bits = 4'd2;
      MODE_8PSK:  bits = 4'd3;
      MODE_16QAM: bits = 4'd4;
      MODE_32QAM: bits = 4'd5;
      MODE_64QAM: bits = 4'd6;
      default:    bits = 4'd8;
    endcase
    return bits;
  endfunction

  function automatic logic [7:0] mode_last_index(mode_t mode);
    logic [8:0] span;
    span = (9'd1 << mode_bits(mode)) - 9'd1;
    return span[7:0];
  endfunction

  // odd level 2*n - side_m1
  function automatic logic signed [4:0] grid_level(logic [3:0] n, logic [3:0] side_m1);
    logic [5:0] lvl;
    lvl = {1'b0, n, 1'b0} - {2'b00, side_m1};
    return signed'(lvl[4:0]);
  endfunction

  function automatic point_level_t point_level(mode_t mode, logic [7:0] idx);
    point_level_t      p;
    logic signed [4:0] edge_lvl;
    p.level_i = 5'sd0;
    p.level_q = 5'sd0;
    p.unit    = UNIT_ONE;
    edge_lvl  = idx[3] ? 5'sd5 : -5'sd5;
    case (mode)
      MODE_BPSK: begin
        p.level_i = idx[0] ? -5'sd1 : 5'sd1;
      end
      MODE_QPSK: begin
        p.level_i = (idx[1:0] == 2'd0 || idx[1:0] == 2'd3) ? 5'sd1 : -5'sd1;
        p.level_q = idx[1] ? -5'sd1 : 5'sd1;
        p.unit    = UNIT_R2;
      end
      MODE_8PSK: begin
        p.unit = idx[0] ? UNIT_R2 : UNIT_ONE;
        case (idx[2:0])
          3'd0:    begin p.level_i = 5'sd1;  p.level_q = 5'sd0;  end
          3'd1:    begin p.level_i = 5'sd1;  p.level_q = 5'sd1;  end
          3'd2:    begin p.level_i = 5'sd0;  p.level_q = 5'sd1;  end
          3'd3:    begin p.level_i = -5'sd1; p.level_q = 5'sd1;  end
          3'd4:    begin p.level_i = -5'sd1; p.level_q = 5'sd0;  end
          3'd5:    begin p.level_i = -5'sd1; p.level_q = -5'sd1; end
          3'd6:    begin p.level_i = 5'sd0;  p.level_q = -5'sd1; end
          default: begin p.level_i = 5'sd1;  p.level_q = -5'sd1; end
        endcase
      end
      MODE_16QAM: begin
        p.level_i = grid_level({2'b00, idx[1:0]}, 4'd3);
        p.level_q = grid_level({2'b00, idx[3:2]}, 4'd3);
        p.unit    = UNIT_R10;
      end
      MODE_32QAM: begin
        p.unit = UNIT_R20;
        if (idx[7:4] != 4'd0) begin
          // outer arms: left column, bottom row, right column, then top row
          if (!idx[2]) begin
            p.level_i = edge_lvl;
            p.level_q = grid_level({2'b00, idx[1:0]}, 4'd3);
          end else begin
            p.level_i = grid_level({2'b00, idx[1:0]}, 4'd3);
            p.level_q = edge_lvl;
          end
        end else begin
          p.level_i = grid_level({2'b00, idx[1:0]}, 4'd3);
          p.level_q = grid_level({2'b00, idx[3:2]}, 4'd3);
        end
      end
      MODE_64QAM: begin
        p.level_i = grid_level({1'b0, idx[2:0]}, 4'd7);
        p.level_q = grid_level({1'b0, idx[5:3]}, 4'd7);
        p.unit    = UNIT_R42;
      end
      default: begin
        p.level_i = grid_level(idx[3:0], 4'd15);
        p.level_q = grid_level(idx[7:4], 4'd15);
        p.unit    = UNIT_R170;
      end
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

@@ sv/pqhd_point_gen.sv @@
// pqhd_point_gen: constellation point generator, one point per cycle with
// registered coordinates. Depends on pqhd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pqhd_point_gen import pqhd_pkg::*; #(
  parameter int FRACTION_BITS = 12
) (
  input  wire logic                            clk_i,
  input  wire mode_t                           mode_i,
  input  wire logic [7:0]                      index_i,
  output logic signed [FRACTION_BITS+1:0]      point_i_o,
  output logic signed [FRACTION_BITS+1:0]      point_q_o
);

  localparam int COORD_W = FRACTION_BITS + 2;
  localparam int SHIFT   = UNIT_FRAC - FRACTION_BITS;
  localparam int MAG_W   = 29;
  localparam logic [MAG_W-1:0] HALF = MAG_W'(1) << (SHIFT - 1);

  point_level_t                lvl;
  logic         [3:0]          abs_i, abs_q;
  logic         [MAG_W-1:0]    prod_i, prod_q;
  logic         [MAG_W-1:0]    rnd_i, rnd_q;
  logic signed  [COORD_W-1:0]  mag_i, mag_q;
  logic signed  [COORD_W-1:0]  point_i_d, point_q_d;

  always_comb begin
    lvl    = point_level(mode_i, index_i);
    abs_i  = lvl.level_i[4] ? 4'(-lvl.level_i) : 4'(lvl.level_i);
    abs_q  = lvl.level_q[4] ? 4'(-lvl.level_q) : 4'(lvl.level_q);
    prod_i = MAG_W'(abs_i) * MAG_W'(lvl.unit);
    prod_q = MAG_W'(abs_q) * MAG_W'(lvl.unit);
    // round half up on the magnitude, sign applied afterwards
    rnd_i  = (prod_i + HALF) >> SHIFT;
    rnd_q  = (prod_q + HALF) >> SHIFT;
    mag_i  = signed'(rnd_i[COORD_W-1:0]);
    mag_q  = signed'(rnd_q[COORD_W-1:0]);
    point_i_d = lvl.level_i[4] ? -mag_i : mag_i;
    point_q_d = lvl.level_q[4] ? -mag_q : mag_q;
  end

  always_ff @(posedge clk_i) begin
    point_i_o <= point_i_d;
    point_q_o <= point_q_d;
  end

endmodule

`default_nettype wire

@@ sv/pqhd_mac.sv @@
// pqhd_mac: shared dual multiplier with registered products and an add or
// subtract on the output. No package dependency.
`timescale 1ns / 1ps
`default_nettype none

module pqhd_mac #(
  parameter int OPERAND_WIDTH = 17
) (
  input  wire logic                              clk_i,
  input  wire logic signed [OPERAND_WIDTH-1:0]   a_i,
  input  wire logic signed [OPERAND_WIDTH-1:0]   b_i,
  input  wire logic signed [OPERAND_WIDTH-1:0]   c_i,
  input  wire logic signed [OPERAND_WIDTH-1:0]   d_i,
  input  wire logic                              sub_i,
  output logic signed [2*OPERAND_WIDTH:0]        sum_o
);

  localparam int PROD_W = 2 * OPERAND_WIDTH;

  logic signed [PROD_W-1:0] p0_q, p1_q;
  logic                     sub_q;

  always_ff @(posedge clk_i) begin
    p0_q  <= a_i * b_i;
    p1_q  <= c_i * d_i;
    sub_q <= sub_i;
  end

  always_comb begin
    if (sub_q) begin
      sum_o = (PROD_W + 1)'(p0_q) - (PROD_W + 1)'(p1_q);
    end else begin
      sum_o = (PROD_W + 1)'(p0_q) + (PROD_W + 1)'(p1_q);
    end
  end

endmodule

`default_nettype wire

@@ sv/psk_qam_hard_demapper.sv @@
// psk_qam_hard_demapper: top level of the hard-decision psk/qam demapper
// with optional differential detection. Depends on pqhd_pkg, pqhd_point_gen, pqhd_mac.
//
//   channel  direction  handshake                 payload
//   -------  ---------  ------------------------  ------------------------------------
//   in       sink       in_valid_i / in_stall_o   sample_i_i, sample_q_i, block_start_i
//   out      source     out_valid_o / out_stall_i symbol_bits_o, bit_count_o
//   cfg      sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// after its transfer a sample is searched against all N points and the best
// index goes to the result register, N being 2 to 256; differential mode first
// forms the conjugate product, which runs through the same multiplier pair
// the rate is set by the one distance unit: one point per cycle
// reset is asynchronous and clears mode, differential flag and history
// a result waiting under out_stall_i does not block the next sample; only a
// finished search with the result register still full waits for it
`timescale 1ns / 1ps
`default_nettype none

module psk_qam_hard_demapper import pqhd_pkg::*; #(
  parameter int SAMPLE_WIDTH  = 16,
  parameter int FRACTION_BITS = 12,
  parameter int MAX_POINTS    = 256
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // sample channel
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic signed [SAMPLE_WIDTH-1:0]  sample_i_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0]  sample_q_i,
  input  wire logic                            block_start_i,
  // result channel
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [7:0]                           symbol_bits_o,
  output logic [3:0]                           bit_count_o,
  // register write channel
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire cfg_index_t                      cfg_index_i,
  input  wire logic [2:0]                      cfg_data_i
);

  // widths: coordinates carry two integer bits, the multiplier operand
  // covers both a sample and a sample-minus-point difference
  localparam int COORD_W = FRACTION_BITS + 2;
  localparam int OPW     = ((SAMPLE_WIDTH > COORD_W) ? SAMPLE_WIDTH : COORD_W) + 1;
  localparam int ACC_W   = 2 * OPW + 1;
  localparam int RND_W   = ACC_W + 1;

  localparam logic [7:0]               LAST_LIMIT = 8'(MAX_POINTS - 1);
  localparam logic signed [RND_W-1:0]  RND_HALF   = RND_W'(1) << (FRACTION_BITS - 1);
  localparam logic signed [RND_W-1:0]  SAT_HI     = RND_W'((1 << (SAMPLE_WIDTH - 1)) - 1);
  localparam logic signed [RND_W-1:0]  SAT_LO     = ~SAT_HI;

  // sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DIFF_X = 3'd1;
  localparam logic [2:0] ST_DIFF_Y = 3'd2;
  localparam logic [2:0] ST_DIFF_W = 3'd3;
  localparam logic [2:0] ST_SEARCH = 3'd4;
  localparam logic [2:0] ST_HOLD   = 3'd5;

  logic [2:0] state_q, state_d;

  // configuration
  mode_t mode_q, mode_d;
  logic  diff_en_q, diff_en_d;
  mode_t eff_mode;

  // sample history and working values
  logic signed [SAMPLE_WIDTH-1:0] prev_re_q, prev_re_d, prev_im_q, prev_im_d;
  logic signed [SAMPLE_WIDTH-1:0] cur_re_q, cur_re_d, cur_im_q, cur_im_d;
  logic signed [SAMPLE_WIDTH-1:0] dec_re_q, dec_re_d, dec_im_q, dec_im_d;
  logic                           have_prev_q, have_prev_d;

  // search pipeline: issue -> point register -> product register -> compare
  logic [7:0]       issue_idx_q, issue_idx_d;
  logic             issuing_q, issuing_d;
  logic             v1_q, v1_d, v2_q, v2_d;
  logic [7:0]       idx1_q, idx1_d, idx2_q, idx2_d;
  logic [7:0]       best_idx_q, best_idx_d;
  logic [ACC_W-1:0] best_d_q, best_d_d;
  logic [7:0]       last_idx;

  // result register
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_bits_q, out_bits_d;
  logic [3:0] out_count_q, out_count_d;

  // shared arithmetic
  logic signed [COORD_W-1:0] point_re, point_im;
  logic signed [OPW-1:0]     diff_re, diff_im;
  logic signed [OPW-1:0]     mac_a, mac_b, mac_c, mac_d;
  logic                      mac_sub;
  logic signed [ACC_W-1:0]   mac_sum;
  logic signed [RND_W-1:0]   rnd_full, rnd_shift;
  logic signed [SAMPLE_WIDTH-1:0] rnd_sat;
  logic                      in_accept, out_free;

  assign eff_mode = effective_mode(mode_q);
  assign last_idx = (mode_last_index(eff_mode) > LAST_LIMIT) ? LAST_LIMIT
                                                             : mode_last_index(eff_mode);

  assign in_stall_o    = (state_q != ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign out_valid_o   = out_valid_q;
  assign symbol_bits_o = out_bits_q;
  assign bit_count_o   = out_count_q;

  assign in_accept = in_valid_i && (state_q == ST_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;

  pqhd_point_gen #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_point_gen (
    .clk_i     (clk_i),
    .mode_i    (eff_mode),
    .index_i   (issue_idx_q),
    .point_i_o (point_re),
    .point_q_o (point_im)
  );

  // differences against the point registered in the previous cycle
  assign diff_re = OPW'(dec_re_q) - OPW'(point_re);
  assign diff_im = OPW'(dec_im_q) - OPW'(point_im);

  // operand selection: conjugate product terms, else squared distance
  always_comb begin
    case (state_q)
      ST_DIFF_X: begin
        mac_a   = OPW'(cur_re_q);
        mac_b   = OPW'(prev_re_q);
        mac_c   = OPW'(cur_im_q);
        mac_d   = OPW'(prev_im_q);
        mac_sub = 1'b0;
      end
      ST_DIFF_Y: begin
        mac_a   = OPW'(cur_im_q);
        mac_b   = OPW'(prev_re_q);
        mac_c   = OPW'(cur_re_q);
        mac_d   = OPW'(prev_im_q);
        mac_sub = 1'b1;
      end
      default: begin
        mac_a   = diff_re;
        mac_b   = diff_re;
        mac_c   = diff_im;
        mac_d   = diff_im;
        mac_sub = 1'b0;
      end
    endcase
  end

  pqhd_mac #(
    .OPERAND_WIDTH (OPW)
  ) u_mac (
    .clk_i (clk_i),
    .a_i   (mac_a),
    .b_i   (mac_b),
    .c_i   (mac_c),
    .d_i   (mac_d),
    .sub_i (mac_sub),
    .sum_o (mac_sum)
  );

  // round half up to the sample format, then saturate
  always_comb begin
    rnd_full  = RND_W'(mac_sum) + RND_HALF;
    rnd_shift = rnd_full >>> FRACTION_BITS;
    if (rnd_shift > SAT_HI) begin
      rnd_sat = SAT_HI[SAMPLE_WIDTH-1:0];
    end else if (rnd_shift < SAT_LO) begin
      rnd_sat = SAT_LO[SAMPLE_WIDTH-1:0];
    end else begin
      rnd_sat = rnd_shift[SAMPLE_WIDTH-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    diff_en_d   = diff_en_q;
    prev_re_d   = prev_re_q;
    prev_im_d   = prev_im_q;
    cur_re_d    = cur_re_q;
    cur_im_d    = cur_im_q;
    dec_re_d    = dec_re_q;
    dec_im_d    = dec_im_q;
    have_prev_d = have_prev_q;
    issue_idx_d = issue_idx_q;
    issuing_d   = issuing_q;
    v1_d        = 1'b0;
    v2_d        = v1_q;
    idx1_d      = issue_idx_q;
    idx2_d      = idx1_q;
    best_idx_d  = best_idx_q;
    best_d_d    = best_d_q;
    out_valid_d = out_valid_q;
    out_bits_d  = out_bits_q;
    out_count_d = out_count_q;

    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MODULATION_MODE:     mode_d    = cfg_data_i;
        CFG_DIFFERENTIAL_ENABLE: diff_en_d = cfg_data_i[0];
        default: ;
      endcase
    end

    // result taken downstream
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          have_prev_d = 1'b1;
          if (diff_en_q && (block_start_i || !have_prev_q)) begin
            // reference sample only
            prev_re_d = sample_i_i;
            prev_im_d = sample_q_i;
          end else if (diff_en_q) begin
            cur_re_d = sample_i_i;
            cur_im_d = sample_q_i;
            state_d  = ST_DIFF_X;
          end else begin
            prev_re_d   = sample_i_i;
            prev_im_d   = sample_q_i;
            dec_re_d    = sample_i_i;
            dec_im_d    = sample_q_i;
            issue_idx_d = 8'd0;
            issuing_d   = 1'b1;
            state_d     = ST_SEARCH;
          end
        end
      end
      ST_DIFF_X: begin
        state_d = ST_DIFF_Y;
      end
      ST_DIFF_Y: begin
        // real part of sample times conjugate of previous
        dec_re_d  = rnd_sat;
        prev_re_d = cur_re_q;
        prev_im_d = cur_im_q;
        state_d   = ST_DIFF_W;
      end
      ST_DIFF_W: begin
        dec_im_d    = rnd_sat;
        issue_idx_d = 8'd0;
        issuing_d   = 1'b1;
        state_d     = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (issuing_q) begin
          v1_d = 1'b1;
          if (issue_idx_q == last_idx) begin
            issuing_d = 1'b0;
          end else begin
            issue_idx_d = issue_idx_q + 8'd1;
          end
        end
        if (v2_q) begin
          // strict compare keeps the lower index on a tie
          if (idx2_q == 8'd0 || $unsigned(mac_sum) < best_d_q) begin
            best_idx_d = idx2_q;
            best_d_d   = $unsigned(mac_sum);
          end
          if (idx2_q == last_idx) begin
            state_d = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_bits_d  = best_idx_q;
          out_count_d = mode_bits(eff_mode);
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MODE_BPSK;
      diff_en_q   <= 1'b0;
      have_prev_q <= 1'b0;
      issuing_q   <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      diff_en_q   <= diff_en_d;
      have_prev_q <= have_prev_d;
      issuing_q   <= issuing_d;
      v1_q        <= v1_d;
      v2_q        <= v2_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    prev_re_q   <= prev_re_d;
    prev_im_q   <= prev_im_d;
    cur_re_q    <= cur_re_d;
    cur_im_q    <= cur_im_d;
    dec_re_q    <= dec_re_d;
    dec_im_q    <= dec_im_d;
    issue_idx_q <= issue_idx_d;
    idx1_q      <= idx1_d;
    idx2_q      <= idx2_d;
    best_idx_q  <= best_idx_d;
    best_d_q    <= best_d_d;
    out_bits_q  <= out_bits_d;
    out_count_q <= out_count_d;
  end

  // compare stage only ever runs inside a search
  a_compare_in_search : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> (state_q == ST_SEARCH))
    else $error("compare stage active outside search");

  // a new result only comes from the hold state
  a_result_from_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_HOLD))
    else $error("result raised without a finished search");

  // decided index stays within the searched range
  a_best_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HOLD) |-> (best_idx_q <= last_idx))
    else $error("decided index beyond the last searched point");

  // issue counter never runs past the last point
  a_issue_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    issuing_q |-> (issue_idx_q <= last_idx))
    else $error("point index issued beyond the last point");

endmodule

`default_nettype wire
